@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file rdst_checker.sv.
// No dependencies; take in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, masked while reset is high through disable iff.
`define RDST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rdst assertion failed");
// Implication form.
`define RDST_ASSERT_IMP(label, clk, rst, ante, cons) \
   `RDST_ASSERT(label, clk, rst, (ante) |-> (cons))
`endif

@@ hdl/rdst_pkg.sv @@
// Shared types and constants for the reverse-delete spanning tree block.
// No dependencies.
package rdst_pkg;
   localparam int MAX_EDGES  = 64;
   localparam int VERT_SLOTS = 64;
   localparam int EIDX_W     = 6;
   localparam int ECNT_W     = 7;
   localparam int VIDX_W     = 6;
   localparam int VCNT_W     = 7;
   localparam int WEIGHT_W   = 16;

   typedef struct packed {
      logic [VIDX_W-1:0]          from_v;
      logic [VIDX_W-1:0]          to_v;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef enum logic [7:0] {
      ST_LOAD   = 8'b0000_0001,
      ST_PREP   = 8'b0000_0010,
      ST_TSEL   = 8'b0000_0100,
      ST_TEST   = 8'b0000_1000,
      ST_DECIDE = 8'b0001_0000,
      ST_OSEL   = 8'b0010_0000,
      ST_EMIT   = 8'b0100_0000,
      ST_NONE   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic start;
      logic run;
      logic sel;
      logic outsel;
      logic reach_init;
      logic decide;
      logic clr_done;
      logic emit;
      logic emit_none;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic found;
      logic changed;
      logic kept_zero;
      logic out_free;
   } status_type;
endpackage

@@ hdl/rdst_ctrl.sv @@
// Sequencer for load, trial deletion and emission phases.
// Depends on rdst_pkg.
module rdst_ctrl import rdst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_edge,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid && req_last_edge) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep  = 1'b1;
            cmd.start = 1'b1;
            state_in  = ST_TSEL;
         end
         ST_TSEL: begin
            cmd.run = 1'b1;
            cmd.sel = 1'b1;
            if (stat.sweep_done) begin
               cmd.start = 1'b1;
               if (stat.found) begin
                  cmd.reach_init = 1'b1;
                  state_in = ST_TEST;
               end else begin
                  cmd.clr_done = 1'b1;
                  state_in = stat.kept_zero ? ST_NONE : ST_OSEL;
               end
            end
         end
         ST_TEST: begin
            cmd.run = 1'b1;
            if (stat.sweep_done) begin
               if (stat.changed) cmd.start = 1'b1;
               else state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            cmd.start  = 1'b1;
            state_in   = ST_TSEL;
         end
         ST_OSEL: begin
            cmd.run    = 1'b1;
            cmd.sel    = 1'b1;
            cmd.outsel = 1'b1;
            if (stat.sweep_done) begin
               if (stat.found) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.finish = 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit  = 1'b1;
               cmd.start = 1'b1;
               state_in  = ST_OSEL;
            end
         end
         ST_NONE: begin
            if (stat.out_free) begin
               cmd.emit_none = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end
endmodule

@@ hdl/rdst_dpath.sv @@
// Edge store, sweep counter, selection, reachability and result register.
// Depends on rdst_pkg.
module rdst_dpath import rdst_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 stat,
   input  logic                       csr_wr_en,
   input  logic [VCNT_W-1:0]          csr_wr_data,
   input  logic [VIDX_W-1:0]          req_edge_from,
   input  logic [VIDX_W-1:0]          req_edge_to,
   input  logic signed [WEIGHT_W-1:0] req_edge_weight,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [VIDX_W-1:0]          rsp_kept_from,
   output logic [VIDX_W-1:0]          rsp_kept_to,
   output logic signed [WEIGHT_W-1:0] rsp_kept_weight,
   output logic                       rsp_final_result,
   output logic                       rsp_none_kept,
   output logic                       rsp_input_error
);
   edge_type                mem [MAX_EDGES];
   edge_type                rd_ff, best_ff;
   logic [VCNT_W-1:0]       vcount_ff, n_eff;
   logic [ECNT_W-1:0]       cnt_ff, idx_ff, kept_ff, rem_ff;
   logic [EIDX_W-1:0]       pidx_ff, best_idx_ff;
   logic                    pval_ff, err_ff, found_ff, chg_ff, rsp_valid_ff;
   logic [MAX_EDGES-1:0]    alive_ff, done_ff;
   logic [VERT_SLOTS-1:0]   reach_ff, reach_in, vmask;
   logic                    wr_ok, rd_go, cand, take, tst, ra, rb, connected;

   assign n_eff = (vcount_ff > VCNT_W'(VERT_SLOTS)) ? VCNT_W'(VERT_SLOTS) : vcount_ff;
   assign wr_ok = (cnt_ff < ECNT_W'(MAX_EDGES)) && ({1'b0, req_edge_from} < n_eff)
                  && ({1'b0, req_edge_to} < n_eff);
   assign rd_go = cmd.run && (idx_ff < cnt_ff);

   assign cand = cmd.outsel ? (alive_ff[pidx_ff] && !done_ff[pidx_ff]) : !done_ff[pidx_ff];
   assign take = cmd.run && cmd.sel && pval_ff && cand
                 && (!found_ff || (rd_ff.weight > best_ff.weight));
   // trial edge is left out of the reachability sweep
   assign tst  = cmd.run && !cmd.sel && pval_ff && alive_ff[pidx_ff]
                 && (pidx_ff != best_idx_ff);
   assign ra   = reach_ff[rd_ff.from_v];
   assign rb   = reach_ff[rd_ff.to_v];

   always_comb begin
      reach_in = reach_ff;
      if (tst && (ra || rb)) begin
         reach_in[rd_ff.from_v] = 1'b1;
         reach_in[rd_ff.to_v]   = 1'b1;
      end
      for (int i = 0; i < VERT_SLOTS; i++) begin
         vmask[i] = (VCNT_W'(i) < n_eff);
      end
   end

   assign connected = (n_eff != '0) && ((reach_ff & vmask) == vmask);

   assign stat.sweep_done = (idx_ff == cnt_ff) && !pval_ff;
   assign stat.found      = found_ff;
   assign stat.changed    = chg_ff;
   assign stat.kept_zero  = (kept_ff == '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // store write and registered sweep read
   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mem[cnt_ff[EIDX_W-1:0]] <= '{req_edge_from, req_edge_to, req_edge_weight};
      end
      if (rd_go) begin
         rd_ff   <= mem[idx_ff[EIDX_W-1:0]];
         pidx_ff <= idx_ff[EIDX_W-1:0];
      end
      if (take) begin
         best_ff     <= rd_ff;
         best_idx_ff <= pidx_ff;
      end
      reach_ff <= cmd.reach_init ? {{(VERT_SLOTS-1){1'b0}}, 1'b1} : reach_in;
      if (cmd.emit) begin
         rsp_kept_from    <= best_ff.from_v;
         rsp_kept_to      <= best_ff.to_v;
         rsp_kept_weight  <= best_ff.weight;
         rsp_final_result <= (rem_ff == ECNT_W'(1));
         rsp_none_kept    <= 1'b0;
         rsp_input_error  <= err_ff;
      end else if (cmd.emit_none) begin
         rsp_kept_from    <= '0;
         rsp_kept_to      <= '0;
         rsp_kept_weight  <= '0;
         rsp_final_result <= 1'b1;
         rsp_none_kept    <= 1'b1;
         rsp_input_error  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCNT_W'(1);
         cnt_ff       <= '0;
         err_ff       <= 1'b0;
         idx_ff       <= '0;
         pval_ff      <= 1'b0;
         found_ff     <= 1'b0;
         chg_ff       <= 1'b0;
         alive_ff     <= '0;
         done_ff      <= '0;
         kept_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) vcount_ff <= csr_wr_data;
         if (cmd.load) begin
            if (wr_ok) cnt_ff <= cnt_ff + ECNT_W'(1);
            else err_ff <= 1'b1;
         end
         if (cmd.run && !cmd.start) begin
            pval_ff <= rd_go;
            if (rd_go) idx_ff <= idx_ff + ECNT_W'(1);
         end
         if (take) found_ff <= 1'b1;
         if (tst && (ra != rb)) chg_ff <= 1'b1;
         if (cmd.prep) begin
            alive_ff <= '1;
            done_ff  <= '0;
            kept_ff  <= cnt_ff;
         end
         if (cmd.decide) begin
            done_ff[best_idx_ff] <= 1'b1;
            if (connected) begin
               alive_ff[best_idx_ff] <= 1'b0;
               kept_ff <= kept_ff - ECNT_W'(1);
            end
         end
         if (cmd.emit) begin
            done_ff[best_idx_ff] <= 1'b1;
            rem_ff <= rem_ff - ECNT_W'(1);
         end
         if (cmd.clr_done) begin
            done_ff <= '0;
            rem_ff  <= kept_ff;
         end
         if (cmd.start) begin
            idx_ff   <= '0;
            pval_ff  <= 1'b0;
            found_ff <= 1'b0;
            chg_ff   <= 1'b0;
         end
         if (cmd.finish) begin
            cnt_ff <= '0;
            err_ff <= 1'b0;
         end
         if (cmd.emit || cmd.emit_none) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

@@ hdl/reverse_delete_spanning_tree_top.sv @@
// Load: one edge beat per cycle. After the last edge (V vertices): a setup step; per edge a
// selection sweep, up to V reachability sweeps and a decision step; an empty selection sweep;
// then per kept result a selection sweep and an emission with the result side ready, and a
// closing sweep (a single none-kept result instead if none is kept); input stalls.
// Synchronous active-high reset: vertex count 1, edge count and error flag cleared.
// Top level: joins rdst_ctrl and rdst_dpath; depends on rdst_pkg.
module reverse_delete_spanning_tree_top import rdst_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [VCNT_W-1:0]          csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [VIDX_W-1:0]          req_edge_from,
   input  logic [VIDX_W-1:0]          req_edge_to,
   input  logic signed [WEIGHT_W-1:0] req_edge_weight,
   input  logic                       req_last_edge,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [VIDX_W-1:0]          rsp_kept_from,
   output logic [VIDX_W-1:0]          rsp_kept_to,
   output logic signed [WEIGHT_W-1:0] rsp_kept_weight,
   output logic                       rsp_final_result,
   output logic                       rsp_none_kept,
   output logic                       rsp_input_error
);
   cmd_type    cmd;
   status_type stat;

   rdst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_edge (req_last_edge),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   rdst_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_edge_from    (req_edge_from),
      .req_edge_to      (req_edge_to),
      .req_edge_weight  (req_edge_weight),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kept_from    (rsp_kept_from),
      .rsp_kept_to      (rsp_kept_to),
      .rsp_kept_weight  (rsp_kept_weight),
      .rsp_final_result (rsp_final_result),
      .rsp_none_kept    (rsp_none_kept),
      .rsp_input_error  (rsp_input_error)
   );
endmodule

@@ hdl/rdst_checker.sv @@
// Port-level checks for the reverse-delete spanning tree top, bound to it.
// Depends on rdst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rdst_checker import rdst_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [VIDX_W-1:0]          rsp_kept_from,
   input logic [VIDX_W-1:0]          rsp_kept_to,
   input logic signed [WEIGHT_W-1:0] rsp_kept_weight,
   input logic                       rsp_final_result,
   input logic                       rsp_none_kept
);
   logic fields_zero;

   assign fields_zero = (rsp_kept_from == '0) && (rsp_kept_to == '0) && (rsp_kept_weight == '0);

   `RDST_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid)
   `RDST_ASSERT_IMP(a_none_final, clock, reset, rsp_valid && rsp_none_kept, rsp_final_result)
   `RDST_ASSERT_IMP(a_none_zero, clock, reset, rsp_valid && rsp_none_kept, fields_zero)
   `RDST_ASSERT_IMP(a_no_load_mid_graph, clock, reset, rsp_valid && !rsp_final_result, !req_ready)
endmodule

bind reverse_delete_spanning_tree_top rdst_checker u_rdst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kept_from    (rsp_kept_from),
   .rsp_kept_to      (rsp_kept_to),
   .rsp_kept_weight  (rsp_kept_weight),
   .rsp_final_result (rsp_final_result),
   .rsp_none_kept    (rsp_none_kept)
);

@@ verif/tb.sv @@
// Self-checking testbench for reverse_delete_spanning_tree_top: graphs of edges go in
// and the kept spanning edges are checked against an in-bench reverse-delete predictor.
// Depends on rdst_pkg and the RTL top level only.
module tb import rdst_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [VIDX_W-1:0]          from_v;
      logic [VIDX_W-1:0]          to_v;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       final_r;
      logic                       none_k;
      logic                       err;
   } kept_rec;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       csr_wr_en = 0;
   logic [VCNT_W-1:0]          csr_wr_data = '0;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic [VIDX_W-1:0]          req_edge_from = '0;
   logic [VIDX_W-1:0]          req_edge_to = '0;
   logic signed [WEIGHT_W-1:0] req_edge_weight = '0;
   logic                       req_last_edge = 0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic [VIDX_W-1:0]          rsp_kept_from;
   logic [VIDX_W-1:0]          rsp_kept_to;
   logic signed [WEIGHT_W-1:0] rsp_kept_weight;
   logic                       rsp_final_result;
   logic                       rsp_none_kept;
   logic                       rsp_input_error;

   // predictor state
   int        vert_count = 1;
   edge_type  graph_edges[MAX_EDGES];
   int        graph_size = 0;
   bit        graph_err = 0;
   kept_rec   kept_q[$];

   int        failures = 0;
   int        sent_items = 0;
   bit        hold_req = 0;
   bit        first_beat = 1;

   reverse_delete_spanning_tree_top dut (.*);

   always #5 clock = ~clock;

   function automatic bit spans_all(bit alive[MAX_EDGES], int cnt, int n);
      int par[VERT_SLOTS];
      int a, b, roots, k, steps;
      if (n == 0) return 0;
      for (int i = 0; i < VERT_SLOTS; i++) par[i] = i;
      for (int i = 0; i < cnt; i++) begin
         if (!alive[i]) continue;
         a = graph_edges[i].from_v;
         steps = 0;
         while (par[a] != a && steps < VERT_SLOTS) begin a = par[a]; steps++; end
         b = graph_edges[i].to_v;
         steps = 0;
         while (par[b] != b && steps < VERT_SLOTS) begin b = par[b]; steps++; end
         if (a != b) par[a] = b;
      end
      roots = 0;
      for (int i = 0; i < n; i++) begin
         k = i;
         steps = 0;
         while (par[k] != k && steps < VERT_SLOTS) begin k = par[k]; steps++; end
         if (k == i) roots++;
      end
      return roots == 1;
   endfunction

   // Apply one accepted edge beat to the predictor; on the last edge queue the tree.
   task automatic predict_tree(edge_type e, bit last);
      int n;
      bit alive[MAX_EDGES];
      edge_type t;
      int j, kept;
      kept_rec r;
      n = (vert_count > VERT_SLOTS) ? VERT_SLOTS : vert_count;
      if (graph_size < MAX_EDGES && e.from_v < n && e.to_v < n) begin
         graph_edges[graph_size] = e;
         graph_size++;
      end else begin
         graph_err = 1;
      end
      if (!last) return;
      // stable sort, heaviest first
      for (int i = 1; i < graph_size; i++) begin
         t = graph_edges[i];
         j = i;
         while (j > 0 && graph_edges[j-1].weight < t.weight) begin
            graph_edges[j] = graph_edges[j-1];
            j--;
         end
         graph_edges[j] = t;
      end
      for (int i = 0; i < MAX_EDGES; i++) alive[i] = 1;
      for (int i = 0; i < graph_size; i++) begin
         alive[i] = 0;
         if (!spans_all(alive, graph_size, n)) alive[i] = 1;
      end
      kept = 0;
      for (int i = 0; i < graph_size; i++) begin
         if (!alive[i]) continue;
         r.from_v = graph_edges[i].from_v;
         r.to_v = graph_edges[i].to_v;
         r.weight = graph_edges[i].weight;
         r.final_r = 0;
         r.none_k = 0;
         r.err = graph_err;
         kept_q = {kept_q, r};
         kept++;
      end
      if (kept == 0) begin
         r = '{from_v: '0, to_v: '0, weight: '0, final_r: 1, none_k: 1, err: graph_err};
         kept_q = {kept_q, r};
      end else begin
         kept_q[$].final_r = 1;
      end
      graph_size = 0;
      graph_err = 0;
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Send one edge beat; valid stays up across back-to-back beats.
   task automatic send_edge(int f, int t, int w, bit last, bit use_gap = 1);
      int gap;
      edge_type e;
      gap = use_gap ? pick_gap() : 0;
      if (gap > 0 || first_beat) begin
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      first_beat = 0;
      req_valid <= 1;
      req_edge_from <= VIDX_W'(f);
      req_edge_to <= VIDX_W'(t);
      req_edge_weight <= WEIGHT_W'(w);
      req_last_edge <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      e.from_v = VIDX_W'(f);
      e.to_v = VIDX_W'(t);
      e.weight = WEIGHT_W'(w);
      predict_tree(e, last);
      sent_items++;
   endtask

   // Drop valid, let all results drain and the block go idle, then a short quiet window.
   task automatic drain();
      @(posedge clock);
      req_valid <= 0;
      first_beat = 1;
      while (kept_q.size() != 0 || !req_ready) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_vertices(int v);
      csr_wr_en <= 1;
      csr_wr_data <= VCNT_W'(v);
      @(posedge clock);
      csr_wr_en <= 0;
      vert_count = v;
      @(posedge clock);
   endtask

   task automatic test_directed();
      set_vertices(4);
      // square with a diagonal, ties on weight and the weight extremes
      send_edge(0, 1, 32767, 0);
      send_edge(1, 2, -32768, 0);
      send_edge(2, 3, 5, 0);
      send_edge(3, 0, 5, 0);
      send_edge(0, 2, 5, 0);
      send_edge(3, 3, 100, 0);       // self loop
      send_edge(4, 1, 7, 1);         // bad vertex
      drain();
      // disconnected: everything kept
      send_edge(0, 1, 3, 0);
      send_edge(1, 0, -1, 1);
      drain();
      // single vertex, self loop only: nothing kept
      set_vertices(1);
      send_edge(0, 0, 9, 1);
      drain();
      set_vertices(0);
      send_edge(0, 0, 1, 0);
      send_edge(63, 63, -5, 1);
      drain();
      // saturated count: vertex 63 valid, graph never spans
      set_vertices(127);
      send_edge(63, 62, 21845, 0);
      send_edge(42, 21, -21846, 1);
      drain();
      set_vertices(64);
      send_edge(63, 0, 1, 0);
      send_edge(0, 63, 2, 1);
      drain();
   endtask

   task automatic test_store_full();
      set_vertices(3);
      for (int i = 0; i < MAX_EDGES + 2; i++)
         send_edge($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 7) - 4,
                   i == MAX_EDGES + 1);
      drain();
   endtask

   task automatic send_random_graph(int n_edges);
      int f, t, w;
      for (int i = 0; i < n_edges; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            f = $urandom_range(0, 63);
            t = $urandom_range(0, 63);
         end else begin
            f = $urandom_range(0, vert_count - 1);
            t = $urandom_range(0, vert_count - 1);
         end
         w = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
         send_edge(f, t, w, i == n_edges - 1);
      end
   endtask

   task automatic test_random_graphs();
      while (sent_items < 260) begin
         if ($urandom_range(0, 7) == 0) set_vertices($urandom_range(20, 64));
         else set_vertices($urandom_range(1, 8));
         send_random_graph($urandom_range(1, 10));
         drain();
      end
   endtask

   task automatic test_backpressure();
      set_vertices(5);
      hold_req = 1;
      send_random_graph(8);
      send_random_graph(6);
      drain();
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_req = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      kept_rec x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (kept_q.size() == 0) begin
            $error("unexpected result beat");
            failures++;
         end else begin
            x = kept_q.pop_front();
            if (rsp_kept_from !== x.from_v) begin
               $error("kept_from exp %0d got %0d", x.from_v, rsp_kept_from); failures++;
            end
            if (rsp_kept_to !== x.to_v) begin
               $error("kept_to exp %0d got %0d", x.to_v, rsp_kept_to); failures++;
            end
            if (rsp_kept_weight !== x.weight) begin
               $error("kept_weight exp %0d got %0d", x.weight, rsp_kept_weight); failures++;
            end
            if (rsp_final_result !== x.final_r) begin
               $error("final_result exp %0d got %0d", x.final_r, rsp_final_result);
               failures++;
            end
            if (rsp_none_kept !== x.none_k) begin
               $error("none_kept exp %0d got %0d", x.none_k, rsp_none_kept); failures++;
            end
            if (rsp_input_error !== x.err) begin
               $error("input_error exp %0d got %0d", x.err, rsp_input_error); failures++;
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("FAIL reverse_delete_spanning_tree_top");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_backpressure();
      test_random_graphs();
      if (failures == 0) begin
         $display("PASS reverse_delete_spanning_tree_top");
      end else begin
         $display("FAIL reverse_delete_spanning_tree_top");
      end
      $finish;
   end
endmodule
